@@ src/ihg_pkg.sv @@
// Shared types and constants for the IPv4 header generator.
// No dependencies; every other file imports this package.
package ihg_pkg;

	localparam int HDR_WORDS  = 5;
	localparam int IDX_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = 2;
	localparam int Q_CNT_W    = 3;

	localparam logic [7:0]       VER_IHL   = 8'h45;
	localparam logic [15:0]      HDR_BYTES = 16'd20;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HDR_WORDS - 1);

	typedef logic [31:0] word_t;
	typedef word_t [HDR_WORDS-1:0] hdr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DSCP  = 3'd0,
		REG_ECN   = 3'd1,
		REG_DF    = 3'd2,
		REG_PROTO = 3'd3,
		REG_SRC   = 3'd4,
		REG_DST   = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [5:0] dscp;
		logic [1:0] ecn;
		logic       df;
		logic [7:0] proto;
		word_t      src;
		word_t      dst;
	} cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ src/ihg_front.sv @@
// Front end: captures a request, assembles the header words and computes
// the header checksum over three pipeline stages. Depends on ihg_pkg.
module ihg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  ihg_pkg::cfg_t    cfg,
	input  logic [15:0]      payload_len,
	input  logic [15:0]      ident,
	input  logic [7:0]       hop_limit,
	input  logic             more_fragments,
	input  logic [12:0]      fragment_offset,
	output logic             push,
	output ihg_pkg::hdr_t    hdr
);
	import ihg_pkg::*;

	logic        valid_s1, valid_s2, push_s3;
	hdr_t        hdr_s1, hdr_s2, hdr_s3;
	logic [18:0] suma_s2;
	logic [17:0] sumb_s2;
	hdr_t        hdr_d;
	logic [15:0] total;
	logic [18:0] suma_d;
	logic [17:0] sumb_d;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;
	hdr_t        hdr_fin;

	// Stage 1 input: the header with the checksum field at zero.
	always_comb begin
		total    = 16'(HDR_BYTES + payload_len);
		hdr_d[0] = {VER_IHL, cfg.dscp, cfg.ecn, total};
		hdr_d[1] = {ident, 1'b0, cfg.df, more_fragments, fragment_offset};
		hdr_d[2] = {hop_limit, cfg.proto, 16'h0000};
		hdr_d[3] = cfg.src;
		hdr_d[4] = cfg.dst;
	end

	// Stage 2 input: two partial sums of the 16-bit halves.
	always_comb begin
		suma_d = 19'(hdr_s1[0][31:16]) + 19'(hdr_s1[0][15:0])
		       + 19'(hdr_s1[1][31:16]) + 19'(hdr_s1[1][15:0])
		       + 19'(hdr_s1[2][31:16]) + 19'(hdr_s1[2][15:0]);
		sumb_d = 18'(hdr_s1[3][31:16]) + 18'(hdr_s1[3][15:0])
		       + 18'(hdr_s1[4][31:16]) + 18'(hdr_s1[4][15:0]);
	end

	// Stage 3 input: combine, fold the carries back twice and invert.
	always_comb begin
		sum     = 20'(suma_s2) + 20'(sumb_s2);
		fold1   = 17'(sum[19:16]) + 17'(sum[15:0]);
		fold2   = 16'(17'(fold1[16]) + 17'(fold1[15:0]));
		hdr_fin = hdr_s2;
		hdr_fin[2][15:0] = ~fold2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			push_s3  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			push_s3  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1 <= hdr_d;
		end
		if (valid_s1) begin
			hdr_s2  <= hdr_s1;
			suma_s2 <= suma_d;
			sumb_s2 <= sumb_d;
		end
		if (valid_s2) begin
			hdr_s3 <= hdr_fin;
		end
	end

	assign push = push_s3;
	assign hdr  = hdr_s3;

endmodule

@@ src/ihg_queue.sv @@
// Small queue of finished headers between the front and back ends.
// Depends on ihg_pkg.
module ihg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ihg_pkg::hdr_t    wr_data,
	input  logic             pop,
	output ihg_pkg::hdr_t    rd_data,
	output ihg_pkg::q_stat_t stat
);
	import ihg_pkg::*;

	hdr_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= Q_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= Q_CNT_W'(count_q - 1'b1);
			end
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));

endmodule

@@ src/ihg_back.sv @@
// Back end: takes one header from the queue and sends it out as five
// registered 32-bit words, one per cycle. Depends on ihg_pkg.
module ihg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ihg_pkg::q_stat_t stat,
	input  ihg_pkg::hdr_t    head,
	output logic             pop,
	output logic             word_valid,
	output logic [31:0]      header_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	import ihg_pkg::*;

	logic             active_q;
	logic [IDX_W-1:0] cnt_q;
	hdr_t             words_q;
	logic             valid_q;
	word_t            word_q;
	logic [IDX_W-1:0] index_q;
	logic             last_q;

	// The next header is loaded while the last word of the current one goes out.
	assign pop = !stat.empty && (!active_q || cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (cnt_q == LAST_IDX) begin
					active_q <= 1'b0;
				end else begin
					cnt_q <= IDX_W'(cnt_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			words_q <= head;
		end
		word_q  <= words_q[cnt_q];
		index_q <= cnt_q;
		last_q  <= (cnt_q == LAST_IDX);
	end

	assign word_valid  = valid_q;
	assign header_word = word_q;
	assign word_index  = index_q;
	assign last_word   = last_q;

endmodule

@@ src/ipv4_header_generator_unit.sv @@
// Top level of the IPv4 header generator: configuration registers, request
// credit count, front end, header queue and back end. Depends on ihg_pkg,
// ihg_front, ihg_queue and ihg_back.
//
//   Channel   Ports                                        Transfer when
//   -------   ------------------------------------------   ------------------------
//   request   payload_len ident hop_limit more_fragments   start high, busy low
//             fragment_offset
//   result    header_word word_index last_word             word_valid high
//   config    cfg_index cfg_wdata                          cfg_we high
//
// Each request produces five header words on consecutive cycles, and the
// single 32-bit result port sets the sustained request rate. Requests may
// arrive back to back: up to four requests can be in the front pipeline
// and the queue at once, and busy rises only when all four slots are taken.
// The receiver cannot stall, so words leave on fixed cycles. Reset clears
// all control state and sets every configuration register to zero.
module ipv4_header_generator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [15:0]                        payload_len,
	input  logic [15:0]                        ident,
	input  logic [7:0]                         hop_limit,
	input  logic                               more_fragments,
	input  logic [12:0]                        fragment_offset,
	output logic                               word_valid,
	output logic [31:0]                        header_word,
	output logic [2:0]                         word_index,
	output logic                               last_word,
	input  logic                               cfg_we,
	input  logic [ihg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ihg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ihg_pkg::*;

	cfg_t               cfg_q;
	logic [Q_CNT_W-1:0] credits_q;
	logic               accept;
	logic               push;
	hdr_t               push_hdr;
	logic               pop;
	hdr_t               head;
	q_stat_t            qstat;

	// Configuration writes. Indexes past the last register are dropped, and
	// bits above each register's width are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_DSCP:  cfg_q.dscp  <= cfg_wdata[5:0];
				REG_ECN:   cfg_q.ecn   <= cfg_wdata[1:0];
				REG_DF:    cfg_q.df    <= cfg_wdata[0];
				REG_PROTO: cfg_q.proto <= cfg_wdata[7:0];
				REG_SRC:   cfg_q.src   <= cfg_wdata;
				REG_DST:   cfg_q.dst   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A credit is taken when a request is transferred and returned when the
	// back end lifts its header out of the queue. Because the front pipeline
	// never stalls, this guarantees a queue slot for every request in flight.
	assign busy   = (credits_q == Q_CNT_W'(Q_DEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
		end else if (accept && !pop) begin
			credits_q <= Q_CNT_W'(credits_q + 1'b1);
		end else if (pop && !accept) begin
			credits_q <= Q_CNT_W'(credits_q - 1'b1);
		end
	end

	ihg_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.cfg             (cfg_q),
		.payload_len     (payload_len),
		.ident           (ident),
		.hop_limit       (hop_limit),
		.more_fragments  (more_fragments),
		.fragment_offset (fragment_offset),
		.push            (push),
		.hdr             (push_hdr)
	);

	ihg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_hdr),
		.pop     (pop),
		.rd_data (head),
		.stat    (qstat)
	);

	ihg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (qstat),
		.head        (head),
		.pop         (pop),
		.word_valid  (word_valid),
		.header_word (header_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// The credit count must keep the queue from overflowing.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("header pushed into a full queue");

	// With no credits out, nothing may sit in the queue.
	a_idle_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(credits_q == '0) |-> qstat.empty)
		else $error("queue holds a header with no request outstanding");

	// Within a header, words follow on consecutive cycles in order.
	a_word_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && !last_word) |=>
			(word_valid && word_index == IDX_W'($past(word_index) + 1'b1)))
		else $error("header words not sent back to back in order");

	// The final-word flag marks the fifth word and no other.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (last_word == (word_index == LAST_IDX)))
		else $error("last_word does not match word_index");

endmodule
